FILE: rtl/necir_pkg.sv
package necir_pkg;

	localparam int unsigned TIME_W     = 16;
	localparam int unsigned FRAME_W    = 32;
	localparam int unsigned BIT_CNT_W  = 5;
	localparam int unsigned MASK_W     = 3;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned CLS_QUEUE_DEPTH = 2;
	localparam int unsigned RES_QUEUE_DEPTH = 2;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd31;

	localparam logic [TIME_W-1:0] RST_ZERO_TIME   = 16'd560;
	localparam logic [TIME_W-1:0] RST_ONE_TIME    = 16'd1680;
	localparam logic [TIME_W-1:0] RST_START_TIME  = 16'd4500;
	localparam logic [TIME_W-1:0] RST_RSTART_TIME = 16'd2250;
	localparam logic [TIME_W-1:0] RST_REND_TIME   = 16'd560;
	localparam logic [TIME_W-1:0] RST_TOLERANCE   = 16'd200;
	localparam logic [MASK_W-1:0] RST_CHECK_MASK  = 3'd3;

	localparam int unsigned MASK_ADDR   = 0;
	localparam int unsigned MASK_CMD    = 1;
	localparam int unsigned MASK_REPEAT = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ZERO_TIME   = 3'd0,
		REG_ONE_TIME    = 3'd1,
		REG_START_TIME  = 3'd2,
		REG_RSTART_TIME = 3'd3,
		REG_REND_TIME   = 3'd4,
		REG_TOLERANCE   = 3'd5,
		REG_CHECK_MASK  = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DATA,
		ST_DONE,
		ST_REPEAT
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] zero_time;
		logic [TIME_W-1:0] one_time;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] rstart_time;
		logic [TIME_W-1:0] rend_time;
		logic [TIME_W-1:0] tolerance;
		logic [MASK_W-1:0] check_mask;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic rstart;
		logic one;
		logic zero;
		logic rend;
	} pulse_class_t;

	localparam int unsigned CLASS_W = $bits(pulse_class_t);
	localparam int unsigned RES_W   = FRAME_W + 1;

	function automatic logic in_window(logic [TIME_W-1:0] w, logic [TIME_W-1:0] nom,
		logic [TIME_W-1:0] tol);
		logic [TIME_W:0] lo_sum;
		logic [TIME_W:0] hi_sum;
		lo_sum = {1'b0, w} + {1'b0, tol};
		hi_sum = {1'b0, nom} + {1'b0, tol};
		return (lo_sum >= {1'b0, nom}) && ({1'b0, w} <= hi_sum);
	endfunction

endpackage

FILE: rtl/nec_ir_pulse_decoder.sv
// NEC infrared pulse decoder. Each request carries one measured pulse width in
// microseconds; the block accepts one request per clock cycle for as long as
// full stays low. The front end compares the width against the start and
// repeat-start windows, and only if both miss against the other three, in
// the cycle it is accepted, and queues the result; the frame engine consumes
// one queued pulse per cycle while the result queue has room. A decoded frame
// or repeat report goes from the class queue through the frame engine into the
// small result queue, where it waits until popped. The timing registers may
// be rewritten only while no pulse is in flight.
module nec_ir_pulse_decoder import necir_pkg::*; #(
	parameter int unsigned CLS_DEPTH = CLS_QUEUE_DEPTH,
	parameter int unsigned RES_DEPTH = RES_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [TIME_W-1:0]    pulse_width,
	output logic                 empty,
	input  logic                 pop,
	output logic [FRAME_W-1:0]   frame_word,
	output logic                 is_repeat,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [TIME_W-1:0]    wr_data
);

	cfg_t               cfg_q;
	pulse_class_t       cls_in;
	pulse_class_t       cls_out;
	logic               cls_empty;
	logic               cls_pop;
	logic               res_full;
	logic               res_push;
	logic [FRAME_W-1:0] res_word;
	logic               res_repeat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_time   <= RST_ZERO_TIME;
			cfg_q.one_time    <= RST_ONE_TIME;
			cfg_q.start_time  <= RST_START_TIME;
			cfg_q.rstart_time <= RST_RSTART_TIME;
			cfg_q.rend_time   <= RST_REND_TIME;
			cfg_q.tolerance   <= RST_TOLERANCE;
			cfg_q.check_mask  <= RST_CHECK_MASK;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ZERO_TIME:   cfg_q.zero_time   <= wr_data;
				REG_ONE_TIME:    cfg_q.one_time    <= wr_data;
				REG_START_TIME:  cfg_q.start_time  <= wr_data;
				REG_RSTART_TIME: cfg_q.rstart_time <= wr_data;
				REG_REND_TIME:   cfg_q.rend_time   <= wr_data;
				REG_TOLERANCE:   cfg_q.tolerance   <= wr_data;
				REG_CHECK_MASK:  cfg_q.check_mask  <= wr_data[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	necir_classify u_classify (
		.cfg         (cfg_q),
		.pulse_width (pulse_width),
		.cls         (cls_in)
	);

	necir_queue #(
		.WIDTH (CLASS_W),
		.DEPTH (CLS_DEPTH)
	) u_cls_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls_in),
		.rd_en   (cls_pop),
		.rd_data (cls_out),
		.full    (full),
		.empty   (cls_empty)
	);

	necir_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cls_valid  (!cls_empty),
		.cls        (cls_out),
		.cls_pop    (cls_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_word   (res_word),
		.res_repeat (res_repeat)
	);

	necir_queue #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data ({res_repeat, res_word}),
		.rd_en   (pop),
		.rd_data ({is_repeat, frame_word}),
		.full    (res_full),
		.empty   (empty)
	);

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !cls_empty)
		else $error("accepted pulse missing from the class queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cls_pop |-> !cls_empty)
		else $error("frame engine consumed from an empty class queue");

endmodule

FILE: rtl/necir_queue.sv
module necir_queue import necir_pkg::*; #(
	parameter int unsigned WIDTH = CLASS_W,
	parameter int unsigned DEPTH = CLS_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/necir_classify.sv
module necir_classify import necir_pkg::*; (
	input  cfg_t              cfg,
	input  logic [TIME_W-1:0] pulse_width,
	output pulse_class_t      cls
);

	logic hit_start;
	logic hit_rstart;

	assign hit_start  = in_window(pulse_width, cfg.start_time, cfg.tolerance);
	assign hit_rstart = in_window(pulse_width, cfg.rstart_time, cfg.tolerance);

	// The start windows take priority, so a hit there hides every later window.
	always_comb begin
		cls        = '0;
		cls.start  = hit_start;
		cls.rstart = hit_rstart && !hit_start;
		if (!hit_start && !hit_rstart) begin
			cls.one  = in_window(pulse_width, cfg.one_time, cfg.tolerance);
			cls.zero = in_window(pulse_width, cfg.zero_time, cfg.tolerance);
			cls.rend = in_window(pulse_width, cfg.rend_time, cfg.tolerance);
		end
	end

endmodule

FILE: rtl/necir_frame.sv
module necir_frame import necir_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               cls_valid,
	input  pulse_class_t       cls,
	output logic               cls_pop,
	input  logic               res_full,
	output logic               res_push,
	output logic [FRAME_W-1:0] res_word,
	output logic               res_repeat
);

	state_t               state_q;
	state_t               state_d;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic [BIT_CNT_W-1:0] cnt_d;
	logic [FRAME_W-1:0]   frame_q;
	logic [FRAME_W-1:0]   frame_d;
	logic                 go;
	logic                 is_bit;
	logic                 bad_addr;
	logic                 bad_cmd;
	logic                 emit;

	assign go      = cls_valid && !res_full;
	assign cls_pop = go;
	assign is_bit  = cls.one || cls.zero;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		frame_d = frame_q;
		if (go) begin
			if (cls.start) begin
				state_d = ST_DATA;
				cnt_d   = '0;
				frame_d = '0;
			end else if (cls.rstart) begin
				state_d = ST_REPEAT;
			end else begin
				unique case (state_q)
					ST_DATA: begin
						if (is_bit) begin
							if (cls.one) begin
								frame_d[~cnt_q] = 1'b1;
							end
							if (cnt_q == LAST_BIT) begin
								state_d = ST_DONE;
							end else begin
								cnt_d = cnt_q + 1'b1;
							end
						end else begin
							state_d = ST_IDLE;
						end
					end
					ST_IDLE, ST_DONE, ST_REPEAT: begin
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
		end
	end

	assign bad_addr = cfg.check_mask[MASK_ADDR] && (frame_d[31:24] != ~frame_d[23:16]);
	assign bad_cmd  = cfg.check_mask[MASK_CMD] && (frame_d[15:8] != ~frame_d[7:0]);

	always_comb begin
		emit       = 1'b0;
		res_repeat = 1'b0;
		if (!cls.start && !cls.rstart) begin
			unique case (state_q)
				ST_DATA: begin
					emit = is_bit && (cnt_q == LAST_BIT) && !bad_addr && !bad_cmd;
				end
				ST_REPEAT: begin
					emit       = cls.rend && cfg.check_mask[MASK_REPEAT];
					res_repeat = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign res_push = go && emit;
	assign res_word = frame_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			frame_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			frame_q <= frame_d;
		end
	end

endmodule

FILE: tb/tb_nec_ir_pulse_decoder.sv
typedef struct packed {
	logic [necir_pkg::FRAME_W-1:0] word;
	logic                          rep;
} nec_result_t;

class frame_scoreboard;
	localparam logic [5:0] PH_IDLE   = 6'd0;
	localparam logic [5:0] PH_DONE   = 6'd33;
	localparam logic [5:0] PH_REPEAT = 6'd40;
	localparam int unsigned MAX_REPORTS = 10;

	logic [necir_pkg::TIME_W-1:0]  zero_t, one_t, start_t, rstart_t, rend_t, tol;
	logic [necir_pkg::MASK_W-1:0]  mask;
	logic [5:0]                    phase;
	logic [necir_pkg::FRAME_W-1:0] frame_bits;
	nec_result_t                   frames_due[$];
	int unsigned                   mismatches;

	function new();
		zero_t     = necir_pkg::RST_ZERO_TIME;
		one_t      = necir_pkg::RST_ONE_TIME;
		start_t    = necir_pkg::RST_START_TIME;
		rstart_t   = necir_pkg::RST_RSTART_TIME;
		rend_t     = necir_pkg::RST_REND_TIME;
		tol        = necir_pkg::RST_TOLERANCE;
		mask       = necir_pkg::RST_CHECK_MASK;
		phase      = PH_IDLE;
		frame_bits = '0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [necir_pkg::REG_IDX_W-1:0] idx,
		logic [necir_pkg::TIME_W-1:0] val);
		case (idx)
			necir_pkg::REG_ZERO_TIME:   zero_t = val;
			necir_pkg::REG_ONE_TIME:    one_t = val;
			necir_pkg::REG_START_TIME:  start_t = val;
			necir_pkg::REG_RSTART_TIME: rstart_t = val;
			necir_pkg::REG_REND_TIME:   rend_t = val;
			necir_pkg::REG_TOLERANCE:   tol = val;
			necir_pkg::REG_CHECK_MASK:  mask = val[necir_pkg::MASK_W-1:0];
			default: ;
		endcase
	endfunction

	function bit in_win(logic [necir_pkg::TIME_W-1:0] w, logic [necir_pkg::TIME_W-1:0] nom);
		int unsigned wi, ni, ti;
		wi = w;
		ni = nom;
		ti = tol;
		return (wi + ti >= ni) && (wi <= ni + ti);
	endfunction

	function void note_pulse(logic [necir_pkg::TIME_W-1:0] w);
		nec_result_t res;
		bit bad_a, bad_c;
		int pos;
		if (in_win(w, start_t)) begin
			phase = 6'd1;
			frame_bits = '0;
			return;
		end
		if (in_win(w, rstart_t)) begin
			phase = PH_REPEAT;
			return;
		end
		if (phase >= 6'd1 && phase <= 6'd32) begin
			pos = 32 - int'(phase);
			if (in_win(w, one_t)) begin
				frame_bits[pos] = 1'b1;
			end else if (!in_win(w, zero_t)) begin
				phase = PH_IDLE;
				return;
			end
			phase = phase + 6'd1;
			if (phase == PH_DONE) begin
				bad_a = mask[necir_pkg::MASK_ADDR] && (frame_bits[31:24] != ~frame_bits[23:16]);
				bad_c = mask[necir_pkg::MASK_CMD] && (frame_bits[15:8] != ~frame_bits[7:0]);
				if (!(bad_a || bad_c)) begin
					res.word = frame_bits;
					res.rep  = 1'b0;
					frames_due.push_back(res);
				end
			end
			return;
		end
		if (phase == PH_REPEAT && in_win(w, rend_t) && mask[necir_pkg::MASK_REPEAT]) begin
			res.word = frame_bits;
			res.rep  = 1'b1;
			frames_due.push_back(res);
		end
	endfunction

	function void check_result(logic [necir_pkg::FRAME_W-1:0] word, logic rep);
		nec_result_t exp_res;
		if (frames_due.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("unexpected result: frame_word %h is_repeat %b", word, rep);
			return;
		end
		exp_res = frames_due.pop_front();
		if (word !== exp_res.word || rep !== exp_res.rep) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch: frame_word exp %h got %h, is_repeat exp %b got %b",
					exp_res.word, word, exp_res.rep, rep);
		end
	endfunction

	function int pending();
		return frames_due.size();
	endfunction
endclass

module tb_nec_ir_pulse_decoder import necir_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned PHASES         = 12;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int {K_START, K_RSTART, K_ONE, K_ZERO, K_REND} pulse_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [TIME_W-1:0]    pulse_width;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [FRAME_W-1:0]   frame_word;
	logic                 is_repeat;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [TIME_W-1:0]    wr_data;

	frame_scoreboard sb;
	cfg_t            cur;
	bit              quiet;
	int unsigned     idle_rate;
	int unsigned     stall_rate;
	int unsigned     stall_left;
	int unsigned     idle_cycles;
	int unsigned     sent;

	nec_ir_pulse_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pulse_width(pulse_width),
		.empty(empty),
		.pop(pop),
		.frame_word(frame_word),
		.is_repeat(is_repeat),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(frame_word, is_repeat);
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!quiet && stall_rate != 0 && $urandom_range(1, 100) <= stall_rate)
				stall_left = $urandom_range(1, 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic logic [TIME_W-1:0] nominal(pulse_kind_t k);
		case (k)
			K_START:  return cur.start_time;
			K_RSTART: return cur.rstart_time;
			K_ONE:    return cur.one_time;
			K_ZERO:   return cur.zero_time;
			default:  return cur.rend_time;
		endcase
	endfunction

	function automatic void window_bounds(input logic [TIME_W-1:0] nom,
		output int unsigned lo, output int unsigned hi);
		int unsigned n, t;
		n = nom;
		t = cur.tolerance;
		lo = (n > t) ? n - t : 0;
		hi = (n + t > 65535) ? 65535 : n + t;
	endfunction

	function automatic logic [TIME_W-1:0] window_width(pulse_kind_t k);
		int unsigned lo, hi;
		window_bounds(nominal(k), lo, hi);
		case ($urandom_range(0, 9))
			0:       return 16'(lo);
			1:       return 16'(hi);
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] noise_width();
		int unsigned lo, hi;
		window_bounds(nominal(pulse_kind_t'($urandom_range(0, 4))), lo, hi);
		case ($urandom_range(0, 3))
			0:       return 16'($urandom);
			1:       return (lo > 0) ? 16'(lo - 1) : 16'($urandom);
			2:       return (hi < 65535) ? 16'(hi + 1) : 16'($urandom);
			default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	// One request per call; push stays high across back-to-back requests.
	task automatic send_pulse(input logic [TIME_W-1:0] w);
		if (!quiet && idle_rate != 0 && $urandom_range(1, 100) <= idle_rate) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		push <= 1'b1;
		pulse_width <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_pulse(w);
		sent++;
	endtask

	task automatic send_kind(input pulse_kind_t k);
		send_pulse(window_width(k));
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		case (idx)
			REG_ZERO_TIME:   cur.zero_time = val;
			REG_ONE_TIME:    cur.one_time = val;
			REG_START_TIME:  cur.start_time = val;
			REG_RSTART_TIME: cur.rstart_time = val;
			REG_REND_TIME:   cur.rend_time = val;
			REG_TOLERANCE:   cur.tolerance = val;
			REG_CHECK_MASK:  cur.check_mask = val[MASK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [TIME_W-1:0] z, input logic [TIME_W-1:0] o,
		input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] rs,
		input logic [TIME_W-1:0] re, input logic [TIME_W-1:0] t,
		input logic [MASK_W-1:0] m);
		settle();
		write_reg(REG_ZERO_TIME, z);
		write_reg(REG_ONE_TIME, o);
		write_reg(REG_START_TIME, s);
		write_reg(REG_RSTART_TIME, rs);
		write_reg(REG_REND_TIME, re);
		write_reg(REG_TOLERANCE, t);
		write_reg(REG_CHECK_MASK, {13'($urandom), m});
		write_reg(REG_UNUSED, 16'($urandom));
		wr_en <= 1'b0;
	endtask

	task automatic send_repeats();
		int n;
		n = $urandom_range(1, 4);
		send_kind(K_RSTART);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0)
				send_pulse(noise_width());
			send_kind(K_REND);
		end
	endtask

	task automatic send_frame();
		logic [FRAME_W-1:0] word;
		logic [7:0] a, c;
		int cut;
		a = 8'($urandom);
		c = 8'($urandom);
		word = ($urandom_range(0, 3) != 0) ? {a, ~a, c, ~c} : $urandom;
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 32;
		send_kind(K_START);
		for (int i = 0; i < 32; i++) begin
			if (i == cut) begin
				send_pulse(noise_width());
				break;
			end
			if ($urandom_range(0, 99) == 0)
				send_pulse(noise_width());
			send_kind(word[31 - i] ? K_ONE : K_ZERO);
		end
		if ($urandom_range(0, 1) == 1)
			send_repeats();
	endtask

	task automatic run_episode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			send_frame();
		end else if (r < 80) begin
			send_repeats();
		end else begin
			repeat ($urandom_range(1, 5)) send_pulse(noise_width());
		end
	endtask

	initial begin
		int unsigned first, target;
		sb = new();
		cur = '{RST_ZERO_TIME, RST_ONE_TIME, RST_START_TIME, RST_RSTART_TIME,
			RST_REND_TIME, RST_TOLERANCE, RST_CHECK_MASK};
		arst_n = 1'b0;
		push = 1'b0;
		pulse_width = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		quiet = 1'b0;
		idle_rate = 0;
		stall_rate = 0;
		stall_left = 0;
		idle_cycles = 0;
		sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pulse(16'h0000);
		send_pulse(16'hFFFF);
		send_pulse(RST_START_TIME - RST_TOLERANCE - 16'd1);
		send_pulse(RST_START_TIME + RST_TOLERANCE + 16'd1);
		send_pulse(RST_START_TIME + RST_TOLERANCE);
		send_pulse(RST_ONE_TIME - RST_TOLERANCE - 16'd1);
		send_pulse(RST_START_TIME - RST_TOLERANCE);
		send_pulse(RST_ONE_TIME - RST_TOLERANCE);
		send_pulse(RST_ONE_TIME + RST_TOLERANCE);
		send_pulse(RST_ZERO_TIME - RST_TOLERANCE);
		send_pulse(RST_ZERO_TIME + RST_TOLERANCE);
		send_pulse(RST_ZERO_TIME + RST_TOLERANCE + 16'd1);
		send_pulse(RST_RSTART_TIME - RST_TOLERANCE);
		send_pulse(RST_REND_TIME + RST_TOLERANCE);
		send_pulse(RST_ONE_TIME);
		send_pulse(RST_START_TIME);
		send_pulse(RST_ZERO_TIME);
		send_pulse(RST_RSTART_TIME + RST_TOLERANCE);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: configure(RST_ZERO_TIME, RST_ONE_TIME, RST_START_TIME, RST_RSTART_TIME,
					RST_REND_TIME, RST_TOLERANCE, 3'd7);
				1: configure(16'd0, 16'hFFFF, 16'd30000, 16'd40000, 16'd0, 16'd0, 3'd7);
				2: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'hFFFF, 3'd4);
				3: configure(16'd1000, 16'd1000, 16'd3000, 16'd3100, 16'd1000, 16'd300, 3'd5);
				4: configure(16'hFFFF, 16'd0, 16'd20000, 16'hFFFF, 16'd32768, 16'd0, 3'd6);
				5: configure(16'd50, 16'd600, 16'd64900, 16'd65400, 16'd100, 16'd400, 3'd7);
				PHASES - 1: configure(RST_ZERO_TIME, RST_ONE_TIME, RST_START_TIME,
					RST_RSTART_TIME, RST_REND_TIME, RST_TOLERANCE, 3'd7);
				default: configure(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom_range(0, 1500)),
					3'($urandom));
			endcase
			quiet = (p == PHASES - 1);
			idle_rate = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
			stall_rate = (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 20 : 45);
			if (p == 0)
				send_pulse(cur.rend_time);
			target = (p == 2) ? 40 : 130;
			first = sent;
			while (sent - first < target)
				run_episode();
		end

		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/necir_pkg.sv
rtl/necir_queue.sv
rtl/necir_classify.sv
rtl/necir_frame.sv
rtl/nec_ir_pulse_decoder.sv
tb/tb_nec_ir_pulse_decoder.sv
